@@ src/snbh_pkg.sv @@
// Shared types, constants and a helper function for the n-gram bucket hasher.
package snbh_pkg;

	localparam int MAX_NGRAM      = 8;
	localparam int MAX_CHAR_BYTES = 4;
	localparam int WIN_BYTES      = MAX_NGRAM * MAX_CHAR_BYTES;
	localparam int WIN_W          = $clog2(WIN_BYTES);
	localparam int NB_W           = $clog2(WIN_BYTES + 1);
	localparam int CLEN_W         = 3;
	localparam int SEEN_W         = 9;
	localparam int SEEN_CAP       = 255 + MAX_NGRAM;
	localparam int QDEPTH         = 4;
	localparam int QPTR_W         = $clog2(QDEPTH);

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	localparam logic [2:0] CFG_MIN_N  = 3'd0;
	localparam logic [2:0] CFG_MAX_N  = 3'd1;
	localparam logic [2:0] CFG_BUCKET = 3'd2;
	localparam logic [2:0] CFG_PREFIX = 3'd3;
	localparam logic [2:0] CFG_SUFFIX = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       word_last;
	} in_beat_t;

	typedef struct packed {
		logic [23:0] bucket;
		logic [3:0]  ngram_length;
		logic [7:0]  start_position;
		logic        run_last;
	} out_beat_t;

	// one window event: optionally push a byte, and optionally close a character
	typedef struct packed {
		logic [7:0]        byte_val;
		logic              has_byte;
		logic              close_char;
		logic [CLEN_W-1:0] char_len;
		logic              word_start;
		logic              step_last;
	} evt_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_SETUP, BK_HASH, BK_MOD, BK_EMIT
	} bk_state_t;

	function automatic logic [CLEN_W-1:0] lead_length(input logic [7:0] b);
		logic [CLEN_W-1:0] len;
		if (b < 8'h80)                    len = 3'd1;
		else if (b >= 8'hC0 && b <= 8'hDF) len = 3'd2;
		else if (b >= 8'hE0 && b <= 8'hEF) len = 3'd3;
		else if (b >= 8'hF0 && b <= 8'hF7) len = 3'd4;
		else                               len = 3'd1;
		if (len > CLEN_W'(MAX_CHAR_BYTES)) len = CLEN_W'(MAX_CHAR_BYTES);
		return len;
	endfunction

endpackage

@@ src/snbh_front.sv @@
// Front end: splits input bytes into window events and feeds the event queue.
module snbh_front
	import snbh_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_beat_t in_beat,
	input  logic [7:0] prefix_byte,
	input  logic [7:0] suffix_byte,
	output logic     evt_valid,
	input  logic     evt_stall,
	output evt_t     evt
);
	logic              busy_q;
	logic [1:0]        phase_q;
	in_beat_t          beat_q;
	logic              in_word_q;
	logic [CLEN_W-1:0] pend_q;
	logic [CLEN_W-1:0] cur_q;
	logic              data_close;
	logic [CLEN_W-1:0] data_len;
	logic [CLEN_W-1:0] pend_n;
	logic [CLEN_W-1:0] cur_n;
	logic              has_short;

	// phases: 0 prefix, 1 data, 2 short close, 3 suffix
	assign in_stall = busy_q;

	always_comb begin
		if (pend_q == '0) begin
			cur_n  = 3'd1;
			pend_n = lead_length(beat_q.data_byte) - 3'd1;
		end else begin
			cur_n  = cur_q + 3'd1;
			pend_n = pend_q - 3'd1;
		end
		data_close = (pend_n == '0);
		data_len   = cur_n;
		has_short  = !data_close && beat_q.word_last;
	end

	always_comb begin
		evt = '0;
		evt_valid = busy_q;
		case (phase_q)
			2'd0: begin
				evt.byte_val = prefix_byte;
				evt.has_byte = 1'b1;
				evt.close_char = 1'b1;
				evt.char_len = 3'd1;
				evt.word_start = 1'b1;
				evt.step_last = !beat_q.word_last && !data_close;
			end
			2'd1: begin
				evt.byte_val = beat_q.data_byte;
				evt.has_byte = 1'b1;
				evt.close_char = data_close;
				evt.char_len = data_len;
				evt.step_last = !beat_q.word_last;
			end
			2'd2: begin
				evt.byte_val = 8'd0;
				evt.close_char = 1'b1;
				evt.char_len = cur_q;
			end
			default: begin
				evt.byte_val = suffix_byte;
				evt.has_byte = 1'b1;
				evt.close_char = 1'b1;
				evt.char_len = 3'd1;
				evt.step_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			phase_q <= 2'd0;
			in_word_q <= 1'b0;
			pend_q <= '0;
			cur_q <= '0;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q <= 1'b1;
				phase_q <= in_word_q ? 2'd1 : 2'd0;
				if (!in_word_q) begin
					pend_q <= '0;
					cur_q <= '0;
				end
			end
		end else if (!evt_stall) begin
			case (phase_q)
				2'd0: begin
					phase_q <= 2'd1;
					in_word_q <= 1'b1;
				end
				2'd1: begin
					pend_q <= pend_n;
					cur_q <= cur_n;
					if (!beat_q.word_last) begin
						busy_q <= 1'b0;
					end else if (has_short) begin
						phase_q <= 2'd2;
					end else begin
						phase_q <= 2'd3;
					end
				end
				2'd2: begin
					pend_q <= '0;
					phase_q <= 2'd3;
				end
				default: begin
					busy_q <= 1'b0;
					in_word_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && in_valid) begin
			beat_q <= in_beat;
		end
	end
endmodule

@@ src/snbh_queue.sv @@
// Short event queue between the front end and the hashing back end.
module snbh_queue
	import snbh_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_stall,
	input  evt_t wr_data,
	output logic rd_valid,
	input  logic rd_stall,
	output evt_t rd_data
);
	evt_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push;
	logic              pop;

	assign wr_stall = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign push = wr_valid && !wr_stall;
	assign pop  = rd_valid && !rd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end
endmodule

@@ src/snbh_back.sv @@
// Back end: keeps the byte window and hashes each closing n-gram.
module snbh_back
	import snbh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        evt_valid,
	output logic        evt_stall,
	input  evt_t        evt,
	input  logic [3:0]  min_n,
	input  logic [3:0]  max_n,
	input  logic [23:0] bucket_count,
	output logic        out_valid,
	input  logic        out_stall,
	output out_beat_t   out_beat
);
	bk_state_t         state_q, state_n;
	logic [7:0]        win_q [WIN_BYTES];
	logic [CLEN_W-1:0] clen_q [MAX_NGRAM];
	logic [SEEN_W-1:0] seen_q;
	logic              last_q;
	logic [3:0]        n_q;
	logic [NB_W-1:0]   k_q;
	logic [31:0]       h_q;
	logic [31:0]       rem_q;
	logic [23:0]       bc_q;
	logic [5:0]        mbit_q;
	logic              ov_q;
	out_beat_t         res_q;
	logic              usable;
	logic              take;
	logic              emit_go;
	logic [3:0]        hi_c;
	logic [NB_W:0]     nb_c;
	logic [WIN_W-1:0]  kidx;
	logic [31:0]       hx;
	logic [32:0]       trial;
	logic [31:0]       rem_sh;
	logic [SEEN_W-1:0] st_c;
	logic [7:0]        st_sat;
	logic [3:0]        n_next;
	logic              more;

	assign usable = (bucket_count != '0) && (min_n != '0) && !(max_n < min_n);
	assign evt_stall = (state_q != BK_IDLE);
	assign take = evt_valid && (state_q == BK_IDLE);
	assign emit_go = (state_q == BK_EMIT) && (!ov_q || !out_stall);
	assign out_valid = ov_q;
	assign out_beat = res_q;

	always_comb begin
		nb_c = '0;
		for (int i = 0; i < MAX_NGRAM; i++) begin
			if (4'(i) < n_q) nb_c = nb_c + (NB_W+1)'(clen_q[i]);
		end
		if (nb_c > (NB_W+1)'(WIN_BYTES)) nb_c = (NB_W+1)'(WIN_BYTES);
		kidx = WIN_W'(k_q - 1'b1);
		hx = h_q ^ {24'd0, win_q[kidx]};
		rem_sh = {rem_q[30:0], h_q[31]};
		trial = {1'b0, rem_sh} - {9'd0, bc_q};
		hi_c = max_n;
		if (hi_c > 4'(MAX_NGRAM)) hi_c = 4'(MAX_NGRAM);
		if (SEEN_W'(hi_c) > seen_q) hi_c = 4'(seen_q);
		st_c = seen_q - SEEN_W'(n_q);
		st_sat = (st_c > 9'd255) ? 8'd255 : st_c[7:0];
		n_next = n_q + 4'd1;
		more = (n_next <= hi_c);
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_IDLE: begin
				if (take && evt.close_char && usable) state_n = BK_SETUP;
			end
			BK_SETUP: begin
				state_n = (n_q <= hi_c) ? BK_HASH : BK_IDLE;
			end
			BK_HASH: begin
				if (k_q == '0) state_n = BK_MOD;
			end
			BK_MOD: begin
				if (mbit_q == 6'd32) state_n = BK_EMIT;
			end
			BK_EMIT: begin
				if (!ov_q || !out_stall) state_n = more ? BK_SETUP : BK_IDLE;
			end
			default: state_n = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			seen_q <= '0;
			ov_q <= 1'b0;
			for (int i = 0; i < MAX_NGRAM; i++) clen_q[i] <= '0;
		end else begin
			state_q <= state_n;
			if (emit_go) ov_q <= 1'b1;
			else if (ov_q && !out_stall) ov_q <= 1'b0;
			if (take) begin
				if (evt.close_char) begin
					for (int i = MAX_NGRAM - 1; i > 0; i--) clen_q[i] <= clen_q[i-1];
					clen_q[0] <= evt.char_len;
					if (evt.word_start) seen_q <= 9'd1;
					else if (seen_q < SEEN_W'(SEEN_CAP)) seen_q <= seen_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			last_q <= evt.step_last;
			n_q <= min_n;
			bc_q <= bucket_count;
		end
		case (state_q)
			BK_SETUP: begin
				k_q <= nb_c[NB_W-1:0];
				h_q <= FNV_BASIS;
			end
			BK_HASH: begin
				if (k_q != '0) begin
					h_q <= hx * FNV_PRIME;
					k_q <= k_q - 1'b1;
				end else begin
					rem_q <= '0;
					mbit_q <= '0;
				end
			end
			BK_MOD: begin
				if (mbit_q != 6'd32) begin
					rem_q <= trial[32] ? rem_sh : trial[31:0];
					h_q <= {h_q[30:0], 1'b0};
					mbit_q <= mbit_q + 1'b1;
				end
			end
			BK_EMIT: begin
				if (!ov_q || !out_stall) begin
					res_q.bucket <= rem_q[23:0];
					res_q.ngram_length <= n_q;
					res_q.start_position <= st_sat;
					res_q.run_last <= last_q && !more;
					n_q <= n_next;
				end
			end
			default: ;
		endcase
	end

	// window shift on every accepted event that carries a byte (short close pushes no byte)
	always_ff @(posedge clk) begin
		if (take && evt.has_byte) begin
			for (int i = WIN_BYTES - 1; i > 0; i--) win_q[i] <= win_q[i-1];
			win_q[0] <= evt.byte_val;
		end
	end
endmodule

@@ src/subword_ngram_bucket_hasher_core.sv @@
// Top level of the character n-gram FNV-1a bucket hasher.
// Bytes enter on the in channel; each character end yields one result per
// n-gram length from min_n up to max_n, capped at MAX_NGRAM and at the
// characters seen in the word. Each result runs through the back end steps in
// order: setup, the serial hash loop over its bytes, the bit-serial modulo and
// emit; output stalls hold the emit step. The back end takes no new window
// event until it is idle again; prefix and suffix each add one event.
module subword_ngram_bucket_hasher_core
	import snbh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_beat_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_beat_t   out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	logic [3:0]  min_n_q;
	logic [3:0]  max_n_q;
	logic [23:0] bucket_count_q;
	logic [7:0]  prefix_q;
	logic [7:0]  suffix_q;
	logic        fe_valid, fe_stall, be_valid, be_stall;
	evt_t        fe_evt, be_evt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_n_q <= 4'd3;
			max_n_q <= 4'd6;
			bucket_count_q <= 24'd2000000;
			prefix_q <= 8'd60;
			suffix_q <= 8'd62;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_N:  min_n_q <= cfg_data[3:0];
				CFG_MAX_N:  max_n_q <= cfg_data[3:0];
				CFG_BUCKET: bucket_count_q <= cfg_data;
				CFG_PREFIX: prefix_q <= cfg_data[7:0];
				CFG_SUFFIX: suffix_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	snbh_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_beat(in_data), .prefix_byte(prefix_q), .suffix_byte(suffix_q),
		.evt_valid(fe_valid), .evt_stall(fe_stall), .evt(fe_evt)
	);

	snbh_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(fe_valid), .wr_stall(fe_stall),
		.wr_data(fe_evt), .rd_valid(be_valid), .rd_stall(be_stall), .rd_data(be_evt)
	);

	snbh_back u_back (
		.clk(clk), .arst_n(arst_n), .evt_valid(be_valid), .evt_stall(be_stall),
		.evt(be_evt), .min_n(min_n_q), .max_n(max_n_q), .bucket_count(bucket_count_q),
		.out_valid(out_valid), .out_stall(out_stall), .out_beat(out_data)
	);

	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.bucket < bucket_count_q || bucket_count_q == '0))
		else $error("bucket out of range");
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.ngram_length != 4'd0 && out_data.ngram_length <= 4'd8))
		else $error("bad ngram length");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("result changed while stalled");
endmodule
